// ===== hdl/hal_pkg.sv =====
// Shared types, constants and helper functions for the host address allocator.
// No dependencies; every other file in this folder imports this package.
package hal_pkg;

  localparam int HOST_BITS = 10;
  localparam int CNT_BITS  = HOST_BITS + 1;
  localparam int CFG_BITS  = 4;
  localparam int OFF_BITS  = 5;
  localparam int WORD_BITS = 1 << OFF_BITS;
  localparam int ADDR_BITS = HOST_BITS - OFF_BITS;
  localparam int NUM_WORDS = 1 << ADDR_BITS;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;
  localparam logic [1:0] REQ_NEXT    = 2'd3;

  localparam logic [CFG_BITS-1:0] BITS_RESET = CFG_BITS'(HOST_BITS);

  typedef struct packed {
    logic [1:0]           req_type;
    logic [HOST_BITS-1:0] host;
  } hal_in_t;

  typedef struct packed {
    logic                 ok;
    logic [HOST_BITS-1:0] result_host;
    logic [CNT_BITS-1:0]  free_hosts;
  } hal_out_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clear;
  } hal_map_req_t;

  typedef struct packed {
    logic                 taken;
    logic                 found;
    logic [OFF_BITS-1:0]  pos;
    logic                 last;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
  } hal_word_res_t;

  function automatic logic [CFG_BITS-1:0] eff_bits(input logic [CFG_BITS-1:0] b);
    logic [CFG_BITS-1:0] r;
    r = b;
    if (r < CFG_BITS'(1)) begin
      r = CFG_BITS'(1);
    end
    if (r > CFG_BITS'(HOST_BITS)) begin
      r = CFG_BITS'(HOST_BITS);
    end
    return r;
  endfunction

  function automatic logic [CNT_BITS-1:0] pool_size(input logic [CFG_BITS-1:0] b);
    return CNT_BITS'(1) << eff_bits(b);
  endfunction

  function automatic logic [HOST_BITS-1:0] top_host(input logic [CFG_BITS-1:0] b);
    logic [CNT_BITS-1:0] p;
    p = pool_size(b) - CNT_BITS'(1);
    return p[HOST_BITS-1:0];
  endfunction

endpackage

// ===== hdl/hal_map.sv =====
// Used-mark bitmap held as a word memory with one valid bit per word.
// Depends on hal_pkg; a cleared word reads as all free.
module hal_map
  import hal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  hal_map_req_t         req,
  output logic [WORD_BITS-1:0] rd_word
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== hdl/hal_word.sv =====
// Shared word unit: bit test, set and clear, and lowest-free-bit search.
// Depends on hal_pkg; purely combinational.
module hal_word
  import hal_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [OFF_BITS-1:0]  off,
  input  logic                 first,
  input  logic [HOST_BITS-1:0] top,
  output hal_word_res_t        res
);

  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] one_hot;
  logic                 last;

  assign last    = (addr == top[HOST_BITS-1:OFF_BITS]);
  assign one_hot = WORD_BITS'(1) << off;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = !word[b] && !(first && (OFF_BITS'(b) < off))
                 && !(last && (OFF_BITS'(b) > top[OFF_BITS-1:0]));
    end
  end

  always_comb begin
    res.pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res.pos = OFF_BITS'(b);
      end
    end
    res.found    = |avail;
    res.last     = last;
    res.taken    = word[off];
    res.set_word = word | one_hot;
    res.clr_word = word & ~one_hot;
  end

endmodule

// ===== hdl/host_address_allocator.sv =====
// Host address allocator: allocate, release, query, next-free over a bitmap.
// Allocate, release, query: request registered, word read (ST_READ), evaluated (ST_EVAL),
// result registered; ST_EVAL holds on out_stall, no new request is taken until ST_IDLE.
// Next-free repeats ST_READ/ST_EVAL over 1..32 bitmap words, limited by the single memory
// read port and word unit. Reset (synchronous, rst_n low) frees every host and sets 10
// active bits; a config transfer clears the bitmap at once through per-word valid bits.
module host_address_allocator
  import hal_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hal_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hal_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           req_r, req_nxt;
  logic [HOST_BITS-1:0] host_r, host_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic                 first_r, first_nxt;
  logic [CFG_BITS-1:0]  bits_r, bits_nxt;
  logic [CNT_BITS-1:0]  free_r, free_nxt;
  logic                 out_valid_r, out_valid_nxt;
  hal_out_t             out_data_r, out_data_nxt;

  logic [HOST_BITS-1:0] top;
  logic [WORD_BITS-1:0] rd_word;
  hal_map_req_t         map_req;
  hal_word_res_t        wres;
  logic                 in_xfer, cfg_xfer, slot_free;

  assign top       = top_host(bits_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  hal_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_word (rd_word)
  );

  hal_word u_word (
    .word  (rd_word),
    .addr  (addr_r),
    .off   (host_r[OFF_BITS-1:0]),
    .first (first_r),
    .top   (top),
    .res   (wres)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    host_nxt      = host_r;
    addr_nxt      = addr_r;
    first_nxt     = first_r;
    bits_nxt      = bits_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    map_req       = '0;
    map_req.rd_addr = addr_r;
    map_req.wr_addr = addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_xfer) begin
          bits_nxt      = cfg_data;
          free_nxt      = pool_size(cfg_data);
          map_req.clear = 1'b1;
        end
        if (in_xfer) begin
          req_nxt   = in_data.req_type;
          host_nxt  = in_data.host & top;
          addr_nxt  = host_nxt[HOST_BITS-1:OFF_BITS];
          first_nxt = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        map_req.rd_en = 1'b1;
        state_nxt     = ST_EVAL;
      end
      default: begin
        if ((req_r == REQ_NEXT) && !wres.found && !wres.last) begin
          addr_nxt  = addr_r + ADDR_BITS'(1);
          first_nxt = 1'b0;
          state_nxt = ST_READ;
        end else if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.ok          = 1'b0;
          out_data_nxt.result_host = '0;
          unique case (req_r)
            REQ_ALLOC: begin
              if (!wres.taken) begin
                map_req.wr_en            = 1'b1;
                map_req.wr_data          = wres.set_word;
                out_data_nxt.ok          = 1'b1;
                out_data_nxt.result_host = host_r;
                if (free_r != '0) begin
                  free_nxt = free_r - CNT_BITS'(1);
                end
              end
            end
            REQ_RELEASE: begin
              if (wres.taken) begin
                map_req.wr_en   = 1'b1;
                map_req.wr_data = wres.clr_word;
                out_data_nxt.ok = 1'b1;
                free_nxt        = free_r + CNT_BITS'(1);
              end
            end
            REQ_QUERY: begin
              out_data_nxt.ok = wres.taken;
            end
            default: begin
              if (wres.found) begin
                out_data_nxt.ok          = 1'b1;
                out_data_nxt.result_host = {addr_r, wres.pos};
              end
            end
          endcase
          out_data_nxt.free_hosts = free_nxt;
          state_nxt               = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bits_r      <= BITS_RESET;
      free_r      <= pool_size(BITS_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_r      <= bits_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    host_r     <= host_nxt;
    addr_r     <= addr_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/hal_chk.sv =====
// Port-level checker for the host address allocator, bound to the top level.
// Depends on hal_pkg and host_address_allocator.
module hal_chk
  import hal_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hal_in_t             in_data,
  input logic                out_valid,
  input logic                out_stall,
  input hal_out_t            out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [CFG_BITS-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("Block took no busy state after an input transfer.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.result_host == '0)
    else $error("Failed request reported a nonzero host.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_hosts <= (CNT_BITS'(1) << HOST_BITS))
    else $error("Free count exceeds the largest pool.");

endmodule

bind host_address_allocator hal_chk u_hal_chk (.*);
